@@ design/uabm_pkg.sv @@
// Package for the undirected adjacency bit matrix.
// Holds sizes, action codes and the transaction structs; no dependencies.
package uabm_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VTX_W        = 6;
    localparam int ROW_W        = 64;
    localparam int CNT_W        = 7;
    localparam int ACT_W        = 3;
    localparam int CHUNK_W      = 8;
    localparam int NUM_CHUNKS   = ROW_W / CHUNK_W;
    localparam int CHUNK_IDX_W  = $clog2(NUM_CHUNKS);
    localparam int BIT_IDX_W    = $clog2(CHUNK_W);

    localparam logic [ACT_W-1:0] ACT_ADD    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_HAS    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DEGREE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_LIST   = 3'd4;

    localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = 7'd64;
    localparam logic [CNT_W-1:0] MAX_VERTICES_C   = CNT_W'(MAX_VERTICES);

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [VTX_W-1:0] vertex_a;
        logic [VTX_W-1:0] vertex_b;
    } t_item;

    typedef struct packed {
        logic             edge_present;
        logic [CNT_W-1:0] degree_count;
        logic [VTX_W-1:0] neighbor;
        logic             list_empty;
        logic             last;
        logic             range_error;
    } t_result;

    typedef struct packed {
        logic             load;
        logic             is_list;
        logic [ROW_W-1:0] row;
        logic             self_loop;
    } t_scan_cmd;

    typedef struct packed {
        logic             strobe;
        logic             last;
        logic [VTX_W-1:0] neighbor;
        logic [CNT_W-1:0] degree;
    } t_scan_rsp;

endpackage

@@ design/uabm_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module uabm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/uabm_scan.sv @@
// Row scanner: byte-wise degree count and ascending neighbor listing; a new load restarts it.
// Depends on uabm_pkg.
module uabm_scan
    import uabm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_scan_cmd i_cmd,
    output t_scan_rsp o_rsp
);

    logic                   r_active, n_active;
    logic                   r_list, n_list;
    logic [ROW_W-1:0]       r_row, n_row;
    logic [CHUNK_IDX_W-1:0] r_chunk, n_chunk;
    logic [CNT_W-1:0]       r_deg, n_deg;

    logic [CHUNK_W-1:0]     chunk;
    logic [BIT_IDX_W-1:0]   low_bit;
    logic [BIT_IDX_W:0]     pop;
    logic [ROW_W-1:0]       row_cleared;
    t_scan_rsp              rsp;

    always_comb begin
        chunk   = r_row[r_chunk*CHUNK_W +: CHUNK_W];
        low_bit = '0;
        pop     = '0;
        for (int i = CHUNK_W - 1; i >= 0; i--) begin
            if (chunk[i]) begin
                low_bit = BIT_IDX_W'(i);
            end
        end
        for (int i = 0; i < CHUNK_W; i++) begin
            pop = pop + (BIT_IDX_W+1)'(chunk[i]);
        end
        row_cleared = r_row;
        row_cleared[r_chunk*CHUNK_W +: CHUNK_W] = chunk & (chunk - CHUNK_W'(1));
    end

    always_comb begin
        n_active = r_active;
        n_list   = r_list;
        n_row    = r_row;
        n_chunk  = r_chunk;
        n_deg    = r_deg;
        rsp      = '0;
        if (i_cmd.load) begin
            n_active = 1'b1;
            n_list   = i_cmd.is_list;
            n_row    = i_cmd.row;
            n_chunk  = '0;
            n_deg    = CNT_W'(i_cmd.self_loop);
        end else if (r_active) begin
            if (r_list) begin
                if (chunk == '0) begin
                    n_chunk = r_chunk + CHUNK_IDX_W'(1);
                end else begin
                    n_row        = row_cleared;
                    rsp.strobe   = 1'b1;
                    rsp.neighbor = {r_chunk, low_bit};
                    rsp.last     = (row_cleared == '0);
                    n_active     = ~rsp.last;
                end
            end else begin
                n_deg   = r_deg + CNT_W'(pop);
                n_chunk = r_chunk + CHUNK_IDX_W'(1);
                if (r_chunk == CHUNK_IDX_W'(NUM_CHUNKS - 1)) begin
                    rsp.strobe = 1'b1;
                    rsp.last   = 1'b1;
                    rsp.degree = n_deg;
                    n_active   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
        r_list  <= n_list;
        r_row   <= n_row;
        r_chunk <= n_chunk;
        r_deg   <= n_deg;
    end

    assign o_rsp = rsp;

endmodule

@@ design/undirected_adjacency_bit_matrix.sv @@
// Undirected adjacency bit matrix: rows in a 64x64 RAM, per-row valid flags.
// Errors, clear and unused codes answer from idle; has edge reads row a; add edge
// writes row a, then row b; degree and listing scan row a, one neighbor per result.
// Sequential: busy stays high until the final result; results cannot be stalled.
// Synchronous reset empties the matrix at once (valid flags) and sets count to 64.
// Depends on uabm_pkg, uabm_ram and uabm_scan.
module undirected_adjacency_bit_matrix
    import uabm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_item            i_item,
    output logic             o_strobe,
    output t_result          o_result,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_READ    = 4'b0010,
        ST_WRITE_B = 4'b0100,
        ST_SCAN    = 4'b1000
    } t_state;

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_vertex_count;
    logic [MAX_VERTICES-1:0]   r_valid, n_valid;
    logic                      r_rd_valid;
    t_item                     r_item, n_item;
    logic                      r_strobe, n_strobe;
    t_result                   r_result, n_result;

    logic [CNT_W-1:0]          eff;
    logic [ROW_W-1:0]          mask;
    logic                      a_ok, b_ok;
    logic [ROW_W-1:0]          ram_rdata, row_q, row_m;
    logic                      ram_we;
    logic [VTX_W-1:0]          ram_waddr, ram_raddr;
    logic [ROW_W-1:0]          ram_wdata;
    t_scan_cmd                 scan_cmd;
    t_scan_rsp                 scan_rsp;

    uabm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_VERTICES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    uabm_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (scan_cmd),
        .o_rsp   (scan_rsp)
    );

    always_comb begin
        eff = (r_vertex_count > MAX_VERTICES_C) ? MAX_VERTICES_C : r_vertex_count;
        for (int i = 0; i < ROW_W; i++) begin
            mask[i] = (CNT_W'(i) < eff);
        end
        row_q = r_rd_valid ? ram_rdata : '0;
        row_m = row_q & mask;
    end

    always_comb begin
        n_state   = r_state;
        n_valid   = r_valid;
        n_item    = r_item;
        n_strobe  = 1'b0;
        n_result  = '0;
        ram_we    = 1'b0;
        ram_waddr = r_item.vertex_a;
        ram_wdata = row_q;
        ram_raddr = r_item.vertex_a;
        scan_cmd  = '0;
        a_ok      = ({1'b0, i_item.vertex_a} < eff);
        b_ok      = ({1'b0, i_item.vertex_b} < eff);

        case (r_state)
            ST_IDLE: begin
                ram_raddr = i_item.vertex_a;
                if (start) begin
                    n_item          = i_item;
                    n_result.last   = 1'b1;
                    case (i_item.action)
                        ACT_ADD, ACT_HAS: begin
                            if (a_ok && b_ok) begin
                                n_state = ST_READ;
                            end else begin
                                n_strobe             = 1'b1;
                                n_result.range_error = 1'b1;
                            end
                        end
                        ACT_DEGREE, ACT_LIST: begin
                            if (a_ok) begin
                                n_state = ST_READ;
                            end else begin
                                n_strobe             = 1'b1;
                                n_result.range_error = 1'b1;
                            end
                        end
                        ACT_CLEAR: begin
                            n_valid  = '0;
                            n_strobe = 1'b1;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_result.last = 1'b1;
                case (r_item.action)
                    ACT_HAS: begin
                        n_strobe              = 1'b1;
                        n_result.edge_present = row_q[r_item.vertex_b];
                        n_state               = ST_IDLE;
                    end
                    ACT_ADD: begin
                        ram_we                     = 1'b1;
                        ram_waddr                  = r_item.vertex_a;
                        ram_wdata                  = row_q;
                        ram_wdata[r_item.vertex_b] = 1'b1;
                        n_valid[r_item.vertex_a]   = 1'b1;
                        ram_raddr                  = r_item.vertex_b;
                        n_state                    = ST_WRITE_B;
                    end
                    ACT_DEGREE: begin
                        scan_cmd.load      = 1'b1;
                        scan_cmd.row       = row_m;
                        scan_cmd.self_loop = row_q[r_item.vertex_a];
                        n_state            = ST_SCAN;
                    end
                    ACT_LIST: begin
                        if (row_m == '0) begin
                            n_strobe            = 1'b1;
                            n_result.list_empty = 1'b1;
                            n_state             = ST_IDLE;
                        end else begin
                            scan_cmd.load    = 1'b1;
                            scan_cmd.is_list = 1'b1;
                            scan_cmd.row     = row_m;
                            n_state          = ST_SCAN;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_WRITE_B: begin
                ram_we                     = 1'b1;
                ram_waddr                  = r_item.vertex_b;
                ram_wdata                  = row_q;
                ram_wdata[r_item.vertex_a] = 1'b1;
                n_valid[r_item.vertex_b]   = 1'b1;
                n_strobe                   = 1'b1;
                n_result.last              = 1'b1;
                n_state                    = ST_IDLE;
            end
            ST_SCAN: begin
                if (scan_rsp.strobe) begin
                    n_strobe              = 1'b1;
                    n_result.last         = scan_rsp.last;
                    n_result.neighbor     = scan_rsp.neighbor;
                    n_result.degree_count = scan_rsp.degree;
                    if (scan_rsp.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_valid        <= '0;
            r_strobe       <= 1'b0;
            r_vertex_count <= VERTEX_COUNT_RST;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_vertex_count <= i_cfg_wdata;
            end
        end
        r_rd_valid <= r_valid[ram_raddr];
        r_item     <= n_item;
        r_result   <= n_result;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
